@@ rtl/core/eight_bit_alu_with_flags_macros.svh @@
// Assertion macros shared by the ALU RTL.
// Compile with NO_ASSERTIONS defined to drop every check.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset
`define ALU8F_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ALU assertion failed");

// Next-cycle implication, disabled while in reset
`define ALU8F_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ALU assertion failed");

`else

`define ALU8F_ASSERT_NOW(label, clk, rst, ante, cons)
`define ALU8F_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/alu8f_pkg.sv @@
package alu8f_pkg;

  // Operation codes; codes 28 to 31 are unused
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_CP   = 5'd4,
    OP_AND  = 5'd5,
    OP_OR   = 5'd6,
    OP_XOR  = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_NEG  = 5'd10,
    OP_CPL  = 5'd11,
    OP_DAA  = 5'd12,
    OP_SCF  = 5'd13,
    OP_CCF  = 5'd14,
    OP_RLCA = 5'd15,
    OP_RRCA = 5'd16,
    OP_RLA  = 5'd17,
    OP_RRA  = 5'd18,
    OP_RLC  = 5'd19,
    OP_RRC  = 5'd20,
    OP_RL   = 5'd21,
    OP_RR   = 5'd22,
    OP_SLA  = 5'd23,
    OP_SRA  = 5'd24,
    OP_SRL  = 5'd25,
    OP_SLL  = 5'd26,
    OP_BIT  = 5'd27
  } op_t;

  // Flag byte bit positions
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_C  = 0;

  // Flag masks
  localparam logic [7:0] MASK_ALL6 = 8'hD7;
  localparam logic [7:0] MASK_INC  = 8'hD6;
  localparam logic [7:0] MASK_HN   = 8'h12;
  localparam logic [7:0] MASK_HNC  = 8'h13;
  localparam logic [7:0] MASK_DAA  = 8'hD5;
  localparam logic [7:0] MASK_BIT  = 8'h56;

  // Decimal adjust constants
  localparam logic [7:0] DAA_LO   = 8'h06;
  localparam logic [7:0] DAA_HI   = 8'h60;
  localparam logic [7:0] DAA_LIM  = 8'h99;

  // Signed-boundary operands for inc and dec overflow
  localparam logic [7:0] INC_OVF  = 8'h7F;
  localparam logic [7:0] DEC_OVF  = 8'h80;

  // One result beat from the core
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags;
    logic       writes;
  } res_t;

endpackage

@@ rtl/core/alu8f_core.sv @@
module alu8f_core (
  input  logic [4:0]        op,
  input  logic [7:0]        a,
  input  logic [7:0]        v,
  input  logic [2:0]        bi,
  input  logic [7:0]        fin,
  output alu8f_pkg::res_t   res
);

  logic       cin;
  logic [7:0] ar_a;
  logic [7:0] ar_b;
  logic       ar_cin;
  logic       ar_sub;
  logic [8:0] add9;
  logic [8:0] sub9;
  logic [4:0] addn;
  logic [4:0] subn;
  logic [7:0] ar_r;
  logic [7:0] ar_f;
  logic [7:0] r;
  logic [7:0] f;
  logic [7:0] mask;
  logic       w;
  logic       t;
  logic [7:0] corr;
  logic       daa_c;
  logic       daa_h;
  logic [3:0] low;

  assign cin = fin[alu8f_pkg::FLAG_C];
  assign low = a[3:0];

  // Pick operands for the shared add/subtract unit
  always_comb begin
    ar_a   = a;
    ar_b   = v;
    ar_cin = 1'b0;
    ar_sub = 1'b0;
    case (alu8f_pkg::op_t'(op))
      alu8f_pkg::OP_ADC: ar_cin = cin;
      alu8f_pkg::OP_SUB, alu8f_pkg::OP_CP: ar_sub = 1'b1;
      alu8f_pkg::OP_SBC: begin
        ar_sub = 1'b1;
        ar_cin = cin;
      end
      alu8f_pkg::OP_NEG: begin
        ar_sub = 1'b1;
        ar_a   = 8'h00;
        ar_b   = a;
      end
      default: ;
    endcase
  end

  // Add and subtract with carry in, plus nibble carries
  assign add9 = {1'b0, ar_a} + {1'b0, ar_b} + {8'h00, ar_cin};
  assign sub9 = {1'b0, ar_a} - {1'b0, ar_b} - {8'h00, ar_cin};
  assign addn = {1'b0, ar_a[3:0]} + {1'b0, ar_b[3:0]} + {4'h0, ar_cin};
  assign subn = {1'b0, ar_a[3:0]} - {1'b0, ar_b[3:0]} - {4'h0, ar_cin};

  // Build arithmetic flags
  always_comb begin
    ar_r = ar_sub ? sub9[7:0] : add9[7:0];
    ar_f = 8'h00;
    ar_f[alu8f_pkg::FLAG_S] = ar_r[7];
    ar_f[alu8f_pkg::FLAG_Z] = (ar_r == 8'h00);
    ar_f[alu8f_pkg::FLAG_N] = ar_sub;
    if (ar_sub) begin
      ar_f[alu8f_pkg::FLAG_H]  = subn[4];
      ar_f[alu8f_pkg::FLAG_PV] = (ar_a[7] ^ ar_b[7]) & (ar_a[7] ^ ar_r[7]);
      ar_f[alu8f_pkg::FLAG_C]  = sub9[8];
    end else begin
      ar_f[alu8f_pkg::FLAG_H]  = addn[4];
      ar_f[alu8f_pkg::FLAG_PV] = ~(ar_a[7] ^ ar_b[7]) & (ar_a[7] ^ ar_r[7]);
      ar_f[alu8f_pkg::FLAG_C]  = add9[8];
    end
  end

  // Decimal adjust correction
  always_comb begin
    corr  = 8'h00;
    daa_c = 1'b0;
    if (cin || (a > alu8f_pkg::DAA_LIM)) begin
      corr  = corr | alu8f_pkg::DAA_HI;
      daa_c = 1'b1;
    end
    if (fin[alu8f_pkg::FLAG_H] || (low > 4'd9)) begin
      corr = corr | alu8f_pkg::DAA_LO;
    end
    if (fin[alu8f_pkg::FLAG_N]) begin
      daa_h = fin[alu8f_pkg::FLAG_H] && (low < 4'd6);
    end else begin
      daa_h = (low > 4'd9);
    end
  end

  // Select value, new flags and flag mask per operation
  always_comb begin
    r    = a;
    f    = fin;
    mask = 8'h00;
    w    = 1'b1;
    t    = 1'b0;
    unique case (alu8f_pkg::op_t'(op))
      alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC, alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC,
      alu8f_pkg::OP_NEG: begin
        r    = ar_r;
        f    = ar_f;
        mask = alu8f_pkg::MASK_ALL6;
      end
      alu8f_pkg::OP_CP: begin
        r    = ar_r;
        f    = ar_f;
        mask = alu8f_pkg::MASK_ALL6;
        w    = 1'b0;
      end
      alu8f_pkg::OP_AND, alu8f_pkg::OP_OR, alu8f_pkg::OP_XOR: begin
        case (alu8f_pkg::op_t'(op))
          alu8f_pkg::OP_AND: r = a & v;
          alu8f_pkg::OP_OR:  r = a | v;
          default:           r = a ^ v;
        endcase
        f = 8'h00;
        f[alu8f_pkg::FLAG_S]  = r[7];
        f[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        f[alu8f_pkg::FLAG_H]  = (alu8f_pkg::op_t'(op) == alu8f_pkg::OP_AND);
        f[alu8f_pkg::FLAG_PV] = ~^r;
        mask = alu8f_pkg::MASK_ALL6;
      end
      alu8f_pkg::OP_INC: begin
        r = v + 8'h01;
        f = 8'h00;
        f[alu8f_pkg::FLAG_S]  = r[7];
        f[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        f[alu8f_pkg::FLAG_H]  = (r[3:0] == 4'h0);
        f[alu8f_pkg::FLAG_PV] = (v == alu8f_pkg::INC_OVF);
        mask = alu8f_pkg::MASK_INC;
      end
      alu8f_pkg::OP_DEC: begin
        r = v - 8'h01;
        f = 8'h00;
        f[alu8f_pkg::FLAG_S]  = r[7];
        f[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        f[alu8f_pkg::FLAG_H]  = (r[3:0] == 4'hF);
        f[alu8f_pkg::FLAG_PV] = (v == alu8f_pkg::DEC_OVF);
        f[alu8f_pkg::FLAG_N]  = 1'b1;
        mask = alu8f_pkg::MASK_INC;
      end
      alu8f_pkg::OP_CPL: begin
        r = ~a;
        f = 8'h00;
        f[alu8f_pkg::FLAG_H] = 1'b1;
        f[alu8f_pkg::FLAG_N] = 1'b1;
        mask = alu8f_pkg::MASK_HN;
      end
      alu8f_pkg::OP_DAA: begin
        r = fin[alu8f_pkg::FLAG_N] ? (a - corr) : (a + corr);
        f = 8'h00;
        f[alu8f_pkg::FLAG_S]  = r[7];
        f[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        f[alu8f_pkg::FLAG_H]  = daa_h;
        f[alu8f_pkg::FLAG_PV] = ~^r;
        f[alu8f_pkg::FLAG_C]  = daa_c;
        mask = alu8f_pkg::MASK_DAA;
      end
      alu8f_pkg::OP_SCF: begin
        f = 8'h00;
        f[alu8f_pkg::FLAG_C] = 1'b1;
        mask = alu8f_pkg::MASK_HNC;
        w    = 1'b0;
      end
      alu8f_pkg::OP_CCF: begin
        f = 8'h00;
        f[alu8f_pkg::FLAG_H] = cin;
        f[alu8f_pkg::FLAG_C] = ~cin;
        mask = alu8f_pkg::MASK_HNC;
        w    = 1'b0;
      end
      alu8f_pkg::OP_RLCA, alu8f_pkg::OP_RRCA, alu8f_pkg::OP_RLA, alu8f_pkg::OP_RRA: begin
        case (alu8f_pkg::op_t'(op))
          alu8f_pkg::OP_RLCA: r = {a[6:0], a[7]};
          alu8f_pkg::OP_RRCA: r = {a[0], a[7:1]};
          alu8f_pkg::OP_RLA:  r = {a[6:0], cin};
          default:            r = {cin, a[7:1]};
        endcase
        t = ((alu8f_pkg::op_t'(op) == alu8f_pkg::OP_RLCA) ||
             (alu8f_pkg::op_t'(op) == alu8f_pkg::OP_RLA)) ? a[7] : a[0];
        f = 8'h00;
        f[alu8f_pkg::FLAG_C] = t;
        mask = alu8f_pkg::MASK_HNC;
      end
      alu8f_pkg::OP_RLC, alu8f_pkg::OP_RRC, alu8f_pkg::OP_RL, alu8f_pkg::OP_RR,
      alu8f_pkg::OP_SLA, alu8f_pkg::OP_SRA, alu8f_pkg::OP_SRL, alu8f_pkg::OP_SLL: begin
        case (alu8f_pkg::op_t'(op))
          alu8f_pkg::OP_RLC: begin r = {v[6:0], v[7]};  t = v[7]; end
          alu8f_pkg::OP_RRC: begin r = {v[0], v[7:1]};  t = v[0]; end
          alu8f_pkg::OP_RL:  begin r = {v[6:0], cin};   t = v[7]; end
          alu8f_pkg::OP_RR:  begin r = {cin, v[7:1]};   t = v[0]; end
          alu8f_pkg::OP_SLA: begin r = {v[6:0], 1'b0};  t = v[7]; end
          alu8f_pkg::OP_SRA: begin r = {v[7], v[7:1]};  t = v[0]; end
          alu8f_pkg::OP_SRL: begin r = {1'b0, v[7:1]};  t = v[0]; end
          default:           begin r = {v[6:0], 1'b1};  t = v[7]; end
        endcase
        f = 8'h00;
        f[alu8f_pkg::FLAG_S]  = r[7];
        f[alu8f_pkg::FLAG_Z]  = (r == 8'h00);
        f[alu8f_pkg::FLAG_PV] = ~^r;
        f[alu8f_pkg::FLAG_C]  = t;
        mask = alu8f_pkg::MASK_ALL6;
      end
      alu8f_pkg::OP_BIT: begin
        r = v;
        t = ~v[bi];
        f = 8'h00;
        f[alu8f_pkg::FLAG_Z]  = t;
        f[alu8f_pkg::FLAG_PV] = t;
        f[alu8f_pkg::FLAG_H]  = 1'b1;
        mask = alu8f_pkg::MASK_BIT;
        w    = 1'b0;
      end
      default: begin
        w = 1'b0;
      end
    endcase
  end

  // Merge defined flag bits over the incoming flag byte
  assign res.result = r;
  assign res.flags  = (fin & ~mask) | (f & mask);
  assign res.writes = w;

endmodule

@@ rtl/core/eight_bit_alu_with_flags.sv @@
// Eight-bit ALU with flag byte. Pulse start with opcode, accumulator, operand,
// bit_index and flags_in; the beat is taken whenever busy is low, and busy is
// high only while rst is asserted, so one beat may be issued every cycle.
// Each beat passes through the input register, then the result register, and
// comes back on result, flags_out and writes_result, marked by a one-cycle done
// pulse, in issue order. The receiver cannot stall: a result must be captured
// in the cycle done is high, since the next beat may replace it.
`include "eight_bit_alu_with_flags_macros.svh"

module eight_bit_alu_with_flags (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] opcode,
  input  logic [7:0] accumulator,
  input  logic [7:0] operand,
  input  logic [2:0] bit_index,
  input  logic [7:0] flags_in,
  output logic       done,
  output logic [7:0] result,
  output logic [7:0] flags_out,
  output logic       writes_result
);

  logic            stage_valid;
  logic [4:0]      stage_op;
  logic [7:0]      stage_a;
  logic [7:0]      stage_v;
  logic [2:0]      stage_bi;
  logic [7:0]      stage_flags;
  alu8f_pkg::res_t core_res;
  logic            accept;

  // Hold off beats only during reset
  assign busy   = rst;
  assign accept = start && !busy;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      stage_valid <= accept;
      done        <= stage_valid;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op    <= opcode;
      stage_a     <= accumulator;
      stage_v     <= operand;
      stage_bi    <= bit_index;
      stage_flags <= flags_in;
    end
  end

  alu8f_core u_core (
    .op  (stage_op),
    .a   (stage_a),
    .v   (stage_v),
    .bi  (stage_bi),
    .fin (stage_flags),
    .res (core_res)
  );

  // Register the result beat
  always_ff @(posedge clk) begin
    if (stage_valid) begin
      result        <= core_res.result;
      flags_out     <= core_res.flags;
      writes_result <= core_res.writes;
    end
  end

  `ALU8F_ASSERT_NEXT(a_accept_to_stage, clk, rst, accept, stage_valid)
  `ALU8F_ASSERT_NEXT(a_stage_to_done, clk, rst, stage_valid, done)
  `ALU8F_ASSERT_NOW(a_done_has_source, clk, rst, done, $past(stage_valid))
  `ALU8F_ASSERT_NOW(a_no_write_cmp, clk, rst, done && ($past(stage_op) == alu8f_pkg::OP_CP || $past(stage_op) == alu8f_pkg::OP_BIT || $past(stage_op) == alu8f_pkg::OP_SCF || $past(stage_op) == alu8f_pkg::OP_CCF), !writes_result)
  `ALU8F_ASSERT_NOW(a_unused_passes_flags, clk, rst, done && ($past(stage_op) > 5'(alu8f_pkg::OP_BIT)), flags_out == $past(stage_flags) && !writes_result)

endmodule

@@ tb/eight_bit_alu_with_flags_tb.sv @@
module eight_bit_alu_with_flags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes past the last defined operation
  localparam logic [4:0] OP_FIRST_UNUSED = 5'd28;
  localparam logic [4:0] OP_LAST_CODE    = 5'd31;

  // Flag groups rewritten by each family of operations
  localparam logic [7:0] FLAGS_ALL  = (8'd1 << alu8f_pkg::FLAG_S) | (8'd1 << alu8f_pkg::FLAG_Z) |
                                      (8'd1 << alu8f_pkg::FLAG_H) | (8'd1 << alu8f_pkg::FLAG_PV) |
                                      (8'd1 << alu8f_pkg::FLAG_N) | (8'd1 << alu8f_pkg::FLAG_C);
  localparam logic [7:0] FLAGS_NO_C = FLAGS_ALL & ~(8'd1 << alu8f_pkg::FLAG_C);

  localparam int unsigned RANDOM_BEATS = 1100;
  localparam int unsigned DIRECTED_ROWS = 33;

  typedef struct packed {
    logic [4:0]      op;
    logic [7:0]      a;
    logic [7:0]      v;
    logic [2:0]      bi;
    logic [7:0]      fin;
    logic            typed;
    alu8f_pkg::res_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [4:0] opcode = '0;
  logic [7:0] accumulator = '0;
  logic [7:0] operand = '0;
  logic [2:0] bit_index = '0;
  logic [7:0] flags_in = '0;
  logic       done;
  logic [7:0] result;
  logic [7:0] flags_out;
  logic       writes_result;

  alu8f_pkg::res_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned beats_sent = 0;
  logic [31:0] ops_hit = '0;

  // Directed rows: expectations are typed where they are obvious, else predicted
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{alu8f_pkg::OP_ADD,  8'h00, 8'h00, 3'd0, 8'h00, 1'b1, '{8'h00, 8'h40, 1'b1}},
    '{alu8f_pkg::OP_ADD,  8'hFF, 8'h01, 3'd0, 8'h00, 1'b1, '{8'h00, 8'h51, 1'b1}},
    '{alu8f_pkg::OP_ADD,  8'h7F, 8'h01, 3'd0, 8'h00, 1'b1, '{8'h80, 8'h94, 1'b1}},
    '{alu8f_pkg::OP_ADC,  8'hFF, 8'hFF, 3'd0, 8'hFF, 1'b0, '0},
    '{alu8f_pkg::OP_SUB,  8'h00, 8'h01, 3'd0, 8'h00, 1'b1, '{8'hFF, 8'h93, 1'b1}},
    '{alu8f_pkg::OP_SBC,  8'h80, 8'h00, 3'd0, 8'h01, 1'b0, '0},
    '{alu8f_pkg::OP_CP,   8'h55, 8'h55, 3'd0, 8'h00, 1'b1, '{8'h00, 8'h42, 1'b0}},
    '{alu8f_pkg::OP_AND,  8'hFF, 8'hFF, 3'd0, 8'h00, 1'b1, '{8'hFF, 8'h94, 1'b1}},
    '{alu8f_pkg::OP_OR,   8'h00, 8'h00, 3'd0, 8'hFF, 1'b1, '{8'h00, 8'h6C, 1'b1}},
    '{alu8f_pkg::OP_XOR,  8'hA5, 8'h5A, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_INC,  8'h00, 8'h7F, 3'd0, 8'h01, 1'b0, '0},
    '{alu8f_pkg::OP_INC,  8'h00, 8'hFF, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_DEC,  8'h00, 8'h80, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_DEC,  8'h00, 8'h00, 3'd0, 8'hFF, 1'b0, '0},
    '{alu8f_pkg::OP_NEG,  8'h80, 8'h00, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_CPL,  8'h0F, 8'h00, 3'd0, 8'h00, 1'b1, '{8'hF0, 8'h12, 1'b1}},
    '{alu8f_pkg::OP_DAA,  8'h9A, 8'h00, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_DAA,  8'h15, 8'h00, 3'd0, 8'h12, 1'b0, '0},
    '{alu8f_pkg::OP_SCF,  8'h3C, 8'h00, 3'd0, 8'h00, 1'b1, '{8'h3C, 8'h01, 1'b0}},
    '{alu8f_pkg::OP_CCF,  8'hC3, 8'h00, 3'd0, 8'h01, 1'b0, '0},
    '{alu8f_pkg::OP_RLCA, 8'h80, 8'h00, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_RRCA, 8'h01, 8'h00, 3'd0, 8'hFF, 1'b0, '0},
    '{alu8f_pkg::OP_RLA,  8'h7F, 8'h00, 3'd0, 8'h01, 1'b0, '0},
    '{alu8f_pkg::OP_RRA,  8'hFE, 8'h00, 3'd0, 8'h01, 1'b0, '0},
    '{alu8f_pkg::OP_RLC,  8'h00, 8'h80, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_RRC,  8'h00, 8'h01, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_RL,   8'h00, 8'hFF, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_RR,   8'h00, 8'h00, 3'd0, 8'h01, 1'b0, '0},
    '{alu8f_pkg::OP_SLA,  8'h00, 8'hC0, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_SRA,  8'h00, 8'h81, 3'd0, 8'h00, 1'b0, '0},
    '{alu8f_pkg::OP_SRL,  8'h00, 8'h01, 3'd0, 8'hFF, 1'b0, '0},
    '{alu8f_pkg::OP_SLL,  8'h00, 8'hFF, 3'd0, 8'h00, 1'b0, '0},
    '{OP_LAST_CODE, 8'hAB, 8'hCD, 3'd5, 8'hD7, 1'b1, '{8'hAB, 8'hD7, 1'b0}}
  };

  eight_bit_alu_with_flags dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .accumulator  (accumulator),
    .operand      (operand),
    .bit_index    (bit_index),
    .flags_in     (flags_in),
    .done         (done),
    .result       (result),
    .flags_out    (flags_out),
    .writes_result(writes_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Flags of an add or subtract with carry in: S Z H PV N C
  function automatic logic [7:0] addsub_flags(input logic [7:0] a, input logic [7:0] b,
                                              input logic cin, input logic sub,
                                              output logic [7:0] r);
    logic [8:0] wide;
    logic [4:0] half;
    logic [7:0] f;
    f = '0;
    if (sub) begin
      wide = {1'b0, a} - {1'b0, b} - {8'd0, cin};
      half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
      f[alu8f_pkg::FLAG_N] = 1'b1;
    end else begin
      wide = {1'b0, a} + {1'b0, b} + {8'd0, cin};
      half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    end
    r = wide[7:0];
    f[alu8f_pkg::FLAG_S] = r[7];
    f[alu8f_pkg::FLAG_Z] = (r == 8'd0);
    f[alu8f_pkg::FLAG_H] = half[4];
    f[alu8f_pkg::FLAG_PV] = sub ? ((a[7] ^ b[7]) & (a[7] ^ r[7]))
                                : (~(a[7] ^ b[7]) & (a[7] ^ r[7]));
    f[alu8f_pkg::FLAG_C] = wide[8];
    return f;
  endfunction

  // Flags of logic ops, DAA and CB shifts: sign, zero, parity, given H and C, N clear
  function automatic logic [7:0] parity_flags(input logic [7:0] r, input logic h,
                                              input logic c);
    logic [7:0] f;
    f = '0;
    f[alu8f_pkg::FLAG_S] = r[7];
    f[alu8f_pkg::FLAG_Z] = (r == 8'd0);
    f[alu8f_pkg::FLAG_H] = h;
    f[alu8f_pkg::FLAG_PV] = ~^r;
    f[alu8f_pkg::FLAG_C] = c;
    return f;
  endfunction

  // Compute the value, flag byte and write enable of one operation
  function automatic alu8f_pkg::res_t alu_predict(input logic [4:0] op, input logic [7:0] a,
                                                  input logic [7:0] v, input logic [2:0] bi,
                                                  input logic [7:0] fin);
    logic [7:0] r, f, mask, corr;
    logic [3:0] low;
    logic       w, cin, nh, nc, t;
    alu8f_pkg::res_t out;
    r = a;
    f = '0;
    mask = '0;
    w = 1'b1;
    cin = fin[alu8f_pkg::FLAG_C];
    case (op)
      alu8f_pkg::OP_ADD: begin
        f = addsub_flags(a, v, 1'b0, 1'b0, r); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_ADC: begin
        f = addsub_flags(a, v, cin, 1'b0, r); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_SUB: begin
        f = addsub_flags(a, v, 1'b0, 1'b1, r); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_SBC: begin
        f = addsub_flags(a, v, cin, 1'b1, r); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_CP: begin
        f = addsub_flags(a, v, 1'b0, 1'b1, r);
        mask = FLAGS_ALL;
        w = 1'b0;
      end
      alu8f_pkg::OP_AND: begin
        r = a & v; f = parity_flags(r, 1'b1, 1'b0); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_OR: begin
        r = a | v; f = parity_flags(r, 1'b0, 1'b0); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_XOR: begin
        r = a ^ v; f = parity_flags(r, 1'b0, 1'b0); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_INC: begin
        r = v + 8'd1;
        f[alu8f_pkg::FLAG_S] = r[7];
        f[alu8f_pkg::FLAG_Z] = (r == 8'd0);
        f[alu8f_pkg::FLAG_H] = (r[3:0] == 4'h0);
        f[alu8f_pkg::FLAG_PV] = (v == alu8f_pkg::INC_OVF);
        mask = FLAGS_NO_C;
      end
      alu8f_pkg::OP_DEC: begin
        r = v - 8'd1;
        f[alu8f_pkg::FLAG_S] = r[7];
        f[alu8f_pkg::FLAG_Z] = (r == 8'd0);
        f[alu8f_pkg::FLAG_H] = (r[3:0] == 4'hF);
        f[alu8f_pkg::FLAG_PV] = (v == alu8f_pkg::DEC_OVF);
        f[alu8f_pkg::FLAG_N] = 1'b1;
        mask = FLAGS_NO_C;
      end
      alu8f_pkg::OP_NEG: begin
        f = addsub_flags(8'd0, a, 1'b0, 1'b1, r); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_CPL: begin
        r = ~a;
        f[alu8f_pkg::FLAG_H] = 1'b1;
        f[alu8f_pkg::FLAG_N] = 1'b1;
        mask = alu8f_pkg::MASK_HN;
      end
      alu8f_pkg::OP_DAA: begin
        low = a[3:0];
        corr = '0;
        nc = 1'b0;
        if (cin || a > alu8f_pkg::DAA_LIM) begin
          corr = corr | alu8f_pkg::DAA_HI;
          nc = 1'b1;
        end
        if (fin[alu8f_pkg::FLAG_H] || low > 4'd9) corr = corr | alu8f_pkg::DAA_LO;
        if (fin[alu8f_pkg::FLAG_N]) begin
          r = a - corr;
          nh = fin[alu8f_pkg::FLAG_H] && (low < 4'd6);
        end else begin
          r = a + corr;
          nh = (low > 4'd9);
        end
        f = parity_flags(r, nh, nc);
        mask = alu8f_pkg::MASK_DAA;
      end
      alu8f_pkg::OP_SCF: begin
        f[alu8f_pkg::FLAG_C] = 1'b1; mask = alu8f_pkg::MASK_HNC; w = 1'b0;
      end
      alu8f_pkg::OP_CCF: begin
        f[alu8f_pkg::FLAG_H] = cin;
        f[alu8f_pkg::FLAG_C] = ~cin;
        mask = alu8f_pkg::MASK_HNC;
        w = 1'b0;
      end
      // Accumulator rotates touch only H, N and C
      alu8f_pkg::OP_RLCA: begin
        r = {a[6:0], a[7]}; f[alu8f_pkg::FLAG_C] = a[7]; mask = alu8f_pkg::MASK_HNC;
      end
      alu8f_pkg::OP_RRCA: begin
        r = {a[0], a[7:1]}; f[alu8f_pkg::FLAG_C] = a[0]; mask = alu8f_pkg::MASK_HNC;
      end
      alu8f_pkg::OP_RLA: begin
        r = {a[6:0], cin}; f[alu8f_pkg::FLAG_C] = a[7]; mask = alu8f_pkg::MASK_HNC;
      end
      alu8f_pkg::OP_RRA: begin
        r = {cin, a[7:1]}; f[alu8f_pkg::FLAG_C] = a[0]; mask = alu8f_pkg::MASK_HNC;
      end
      // CB forms act on the operand and set the full flag group
      alu8f_pkg::OP_RLC: begin
        r = {v[6:0], v[7]}; f = parity_flags(r, 1'b0, v[7]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_RRC: begin
        r = {v[0], v[7:1]}; f = parity_flags(r, 1'b0, v[0]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_RL: begin
        r = {v[6:0], cin}; f = parity_flags(r, 1'b0, v[7]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_RR: begin
        r = {cin, v[7:1]}; f = parity_flags(r, 1'b0, v[0]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_SLA: begin
        r = {v[6:0], 1'b0}; f = parity_flags(r, 1'b0, v[7]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_SRA: begin
        r = {v[7], v[7:1]}; f = parity_flags(r, 1'b0, v[0]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_SRL: begin
        r = {1'b0, v[7:1]}; f = parity_flags(r, 1'b0, v[0]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_SLL: begin
        r = {v[6:0], 1'b1}; f = parity_flags(r, 1'b0, v[7]); mask = FLAGS_ALL;
      end
      alu8f_pkg::OP_BIT: begin
        r = v;
        t = ~v[bi];
        f[alu8f_pkg::FLAG_Z] = t;
        f[alu8f_pkg::FLAG_PV] = t;
        f[alu8f_pkg::FLAG_H] = 1'b1;
        mask = alu8f_pkg::MASK_BIT;
        w = 1'b0;
      end
      default: begin r = a; mask = '0; w = 1'b0; end
    endcase
    out.result = r;
    out.flags = (fin & ~mask) | (f & mask);
    out.writes = w;
    return out;
  endfunction

  // Corner bytes a quarter of the time, otherwise anything
  function automatic logic [7:0] draw_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 9))
        0: b = 8'h00;
        1: b = 8'h01;
        2: b = 8'h0F;
        3: b = 8'h10;
        4: b = 8'h7F;
        5: b = 8'h80;
        6: b = 8'h99;
        7: b = 8'h9A;
        8: b = 8'hF0;
        default: b = 8'hFF;
      endcase
    end
    return b;
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic send_beat(input logic [4:0] op, input logic [7:0] a, input logic [7:0] v,
                           input logic [2:0] bi, input logic [7:0] fin,
                           input alu8f_pkg::res_t want);
    start <= 1'b1;
    opcode <= op;
    accumulator <= a;
    operand <= v;
    bit_index <= bi;
    flags_in <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(want);
    beats_sent++;
    ops_hit[op] = 1'b1;
  endtask

  // Drop start for a random gap: mostly none or short, sometimes long
  task automatic idle_sender(input bit steady);
    int unsigned roll, len;
    roll = $urandom_range(0, 99);
    len = 0;
    if (!steady) begin
      if (roll >= 90) len = $urandom_range(8, 40);
      else if (roll >= 55) len = $urandom_range(1, 3);
    end
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding beat has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Check each result beat against the oldest pending expectation
  always @(posedge clk) begin : check_results
    alu8f_pkg::res_t want;
    if (done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat: result=%02h flags=%02h writes=%0b",
                 $time, result, flags_out, writes_result);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result !== want.result) begin
          $display("%0t: result mismatch: expected %02h, got %02h",
                   $time, want.result, result);
          error_count++;
        end
        if (flags_out !== want.flags) begin
          $display("%0t: flags_out mismatch: expected %02h, got %02h",
                   $time, want.flags, flags_out);
          error_count++;
        end
        if (writes_result !== want.writes) begin
          $display("%0t: writes_result mismatch: expected %0b, got %0b",
                   $time, want.writes, writes_result);
          error_count++;
        end
      end
    end else if (!rst && done !== 1'b0) begin
      $display("%0t: done mismatch: expected 0 or 1, got %b", $time, done);
      error_count++;
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    logic [4:0] op;
    logic [7:0] a, v, fin;
    logic [2:0] bi;
    bit         steady;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      send_beat(row.op, row.a, row.v, row.bi, row.fin,
                row.typed ? row.want : alu_predict(row.op, row.a, row.v, row.bi, row.fin));
      idle_sender(i < 12);
    end
    drain_results();

    // Random beats, switching between steady bursts and gappy stretches
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_BEATS / 2) drain_results();
      if ($urandom_range(0, 99) < 6) op = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
      else op = 5'($urandom_range(alu8f_pkg::OP_ADD, alu8f_pkg::OP_BIT));
      a = draw_byte();
      v = draw_byte();
      bi = 3'($urandom_range(0, 7));
      fin = 8'($urandom_range(0, 255));
      send_beat(op, a, v, bi, fin, alu_predict(op, a, v, bi, fin));
      idle_sender(steady);
    end

    // Let the pipeline empty, then keep watching for stray beats
    drain_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d beats (%0d directed), checked %0d results", beats_sent,
             DIRECTED_ROWS, results_checked);
    $display("Opcode values exercised: %0d of 32", $countones(ops_hit));
    if (error_count == 0) begin
      $display("PASS eight_bit_alu_with_flags");
    end else begin
      $display("FAIL eight_bit_alu_with_flags");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still pending", expected_results.size());
    $display("FAIL eight_bit_alu_with_flags");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/alu8f_pkg.sv
rtl/core/alu8f_core.sv
rtl/core/eight_bit_alu_with_flags.sv
tb/eight_bit_alu_with_flags_tb.sv
